/* rtl/ltw_pkg.sv */
// ----------------------------------------------------------------------------
// ltw_pkg
// shared types and constants of the two-wire frame sender for an led driver
// ----------------------------------------------------------------------------
package ltw_pkg;

    // digit bytes sent after the address command (1 to 7)
    localparam int DIGITS   = 4;
    localparam int STORE_AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // segment bytes arriving on the input channel
    localparam int SEG_IN   = 4;
    localparam int SEG_W    = 8 * SEG_IN;

    localparam int BRIGHT_W = 3;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;

    // command bytes
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h88;

    // item kinds on the input channel
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_START0 = 5'd1,
        PH_START1 = 5'd2,
        PH_START2 = 5'd3,
        PH_BLOW   = 5'd4,
        PH_BDATA  = 5'd5,
        PH_BHIGH  = 5'd6,
        PH_ACK0   = 5'd7,
        PH_ACK1   = 5'd8,
        PH_ACK2   = 5'd9,
        PH_STOP0  = 5'd10,
        PH_STOP1  = 5'd11,
        PH_STOP2  = 5'd12,
        PH_STOP3  = 5'd13
    } phase_t;

    // result item, clk_level in the lowest bit
    typedef struct packed {
        logic frame_done;
        logic request_dropped;
        logic busy_res;
        logic dio_drive;
        logic dio_level;
        logic clk_level;
    } result_t;

endpackage

/* rtl/ltw_seq.sv */
// ----------------------------------------------------------------------------
// ltw_seq
// pin sequencer: start, byte, ack and stop timing, one phase per tick item
// ----------------------------------------------------------------------------
module ltw_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            op,
    input  logic                            with_setup,
    input  logic [ltw_pkg::SEG_W-1:0]       seg_data,
    input  logic [ltw_pkg::BRIGHT_W-1:0]    brightness,
    output ltw_pkg::result_t                res
);
    import ltw_pkg::*;

    localparam int SEG_EXT_W = 64;

    phase_t       phase_reg, phase_next;
    logic [2:0]   bit_count_reg, bit_count_next;
    logic [2:0]   byte_index_reg, byte_index_next;
    logic [7:0]   shift_reg, shift_next;
    logic         setup_reg, setup_next;
    logic         clk_reg, clk_next;
    logic         dio_reg, dio_next;
    logic         en_reg, en_next;
    logic [7:0]   store_reg [DIGITS];

    logic                 ticking;
    logic                 loading;
    logic                 dropped;
    logic                 done;
    logic [2:0]           idx_sel;
    logic [2:0]           idx_m1;
    logic [7:0]           store_rd;
    logic [7:0]           cur_byte;
    logic [SEG_EXT_W-1:0] seg_ext;

    assign ticking = step && (op == OP_TICK) && (phase_reg != PH_IDLE);
    assign loading = step && (op == OP_REQUEST) && (phase_reg == PH_IDLE);
    assign dropped = step && (op == OP_REQUEST) && (phase_reg != PH_IDLE);
    assign seg_ext = SEG_EXT_W'(seg_data);

    // byte to load: in the last ack phase the index is taken one ahead
    assign idx_sel  = (phase_reg == PH_ACK2) ? byte_index_reg + 3'd1 : byte_index_reg;
    assign idx_m1   = idx_sel - 3'd1;
    assign store_rd = (idx_m1 < 3'(DIGITS)) ? store_reg[idx_m1[STORE_AW-1:0]] : 8'h00;

    always_comb begin
        if (setup_reg) begin
            cur_byte = (idx_sel == 3'd0) ? CMD_DATA
                                         : (CMD_CTRL | {{(8-BRIGHT_W){1'b0}}, brightness});
        end else begin
            cur_byte = (idx_sel == 3'd0) ? CMD_ADDR : store_rd;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (loading) begin
            phase_next = PH_START0;
        end else if (ticking) begin
            case (phase_reg)
                PH_START0: phase_next = PH_START1;
                PH_START1: phase_next = PH_START2;
                PH_START2: phase_next = PH_BLOW;
                PH_BLOW:   phase_next = PH_BDATA;
                PH_BDATA:  phase_next = PH_BHIGH;
                PH_BHIGH:  phase_next = (bit_count_reg == 3'd7) ? PH_ACK0 : PH_BLOW;
                PH_ACK0:   phase_next = PH_ACK1;
                PH_ACK1:   phase_next = PH_ACK2;
                PH_ACK2: begin
                    phase_next = (!setup_reg && byte_index_reg < 3'(DIGITS)) ? PH_BLOW
                                                                             : PH_STOP0;
                end
                PH_STOP0:  phase_next = PH_STOP1;
                PH_STOP1:  phase_next = PH_STOP2;
                PH_STOP2:  phase_next = PH_STOP3;
                PH_STOP3:  phase_next = setup_reg ? PH_START0 : PH_IDLE;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    // pins, shifter and counters
    always_comb begin
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        shift_next      = shift_reg;
        setup_next      = setup_reg;
        clk_next        = clk_reg;
        dio_next        = dio_reg;
        en_next         = en_reg;
        done            = 1'b0;
        if (loading) begin
            setup_next      = with_setup;
            byte_index_next = 3'd0;
            bit_count_next  = 3'd0;
        end else if (ticking) begin
            case (phase_reg)
                PH_START0: begin
                    dio_next = 1'b1;
                    clk_next = 1'b1;
                    en_next  = 1'b1;
                end
                PH_START1: dio_next = 1'b0;
                PH_START2: begin
                    clk_next       = 1'b0;
                    shift_next     = cur_byte;
                    bit_count_next = 3'd0;
                end
                PH_BLOW:   clk_next = 1'b0;
                PH_BDATA:  dio_next = shift_reg[0];
                PH_BHIGH: begin
                    clk_next       = 1'b1;
                    shift_next     = {1'b0, shift_reg[7:1]};
                    bit_count_next = (bit_count_reg == 3'd7) ? 3'd0 : bit_count_reg + 3'd1;
                end
                PH_ACK0: begin
                    clk_next = 1'b0;
                    en_next  = 1'b0;
                end
                PH_ACK1:   clk_next = 1'b1;
                PH_ACK2: begin
                    clk_next = 1'b0;
                    en_next  = 1'b1;
                    if (!setup_reg && byte_index_reg < 3'(DIGITS)) begin
                        byte_index_next = idx_sel;
                        shift_next      = cur_byte;
                        bit_count_next  = 3'd0;
                    end
                end
                PH_STOP0:  clk_next = 1'b0;
                PH_STOP1:  dio_next = 1'b0;
                PH_STOP2:  clk_next = 1'b1;
                PH_STOP3: begin
                    dio_next = 1'b1;
                    if (setup_reg) begin
                        if (byte_index_reg == 3'd0) begin
                            byte_index_next = 3'd1;
                        end else begin
                            setup_next      = 1'b0;
                            byte_index_next = 3'd0;
                        end
                    end else begin
                        byte_index_next = 3'd0;
                        done            = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.clk_level       = clk_next;
        res.dio_level       = en_next & dio_next;
        res.dio_drive       = en_next;
        res.busy_res        = (phase_next != PH_IDLE);
        res.request_dropped = dropped;
        res.frame_done      = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 3'd0;
            byte_index_reg <= 3'd0;
            shift_reg      <= 8'h00;
            setup_reg      <= 1'b0;
            clk_reg        <= 1'b1;
            dio_reg        <= 1'b1;
            en_reg         <= 1'b1;
        end else begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_index_reg <= byte_index_next;
            shift_reg      <= shift_next;
            setup_reg      <= setup_next;
            clk_reg        <= clk_next;
            dio_reg        <= dio_next;
            en_reg         <= en_next;
        end
    end

    // segment bytes; digits beyond the input item read as zero
    always_ff @(posedge aclk) begin
        if (loading) begin
            for (int i = 0; i < DIGITS; i++) begin
                store_reg[i] <= seg_ext[8*i +: 8];
            end
        end
    end

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.frame_done |-> !res.busy_res)
        else $error("frame done while still busy");

    a_drop_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.request_dropped |-> (phase_reg != PH_IDLE))
        else $error("request dropped while idle");

    a_release_in_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        !en_reg |-> (phase_reg == PH_ACK1 || phase_reg == PH_ACK2))
        else $error("data pin released outside ack slot");

    a_bits_in_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (bit_count_reg != 3'd0) |->
            (phase_reg == PH_BLOW || phase_reg == PH_BDATA || phase_reg == PH_BHIGH))
        else $error("bit count live outside byte phases");

endmodule

/* rtl/led_driver_two_wire_frame_sender_core.sv */
// ----------------------------------------------------------------------------
// led_driver_two_wire_frame_sender_core
// two-wire serial master for a four-digit led driver, stream wrapper
// ----------------------------------------------------------------------------
// usage
//   input items come on the s_ channel; s_tuser[0] picks the kind of item:
//   a tick advances the pin timing by one phase, a request latches the
//   segment bytes in s_tdata and starts a frame sequence (s_tuser[1] adds
//   the data command and display control frames first)
//   every input item yields exactly one result item on the m_ channel with
//   the pin levels after that item plus busy, dropped and done flags
//   a request that arrives while a sequence is running is dropped and flagged
//   the result becomes valid in the cycle after the input item is accepted
//   throughput: one item per cycle unless stalled; the sequencer is a single
//   registered pass; the result register refills in the cycle it empties
//   stall: when m_tready is low and a result is waiting, s_tready drops and
//   no further item is taken until the result is delivered
//   reset: aresetn sampled low puts the sequencer idle, the clock
//   and data pins high and driven, brightness to 7, and empties the result
//   register
//   brightness is to be written through cfg_wr_en / cfg_wr_data while idle,
//   left to the user; sampled when the display control command is loaded
// ----------------------------------------------------------------------------
module led_driver_two_wire_frame_sender_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ltw_pkg::SEG_W-1:0]     s_tdata,   // segment_0 .. segment_3
    input  logic [1:0]                    s_tuser,   // op, with_setup
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // clk_level, dio_level,
                                                     // dio_drive, busy_res,
                                                     // request_dropped,
                                                     // frame_done, 2 zero bits
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [ltw_pkg::BRIGHT_W-1:0]  cfg_wr_data // brightness
);
    import ltw_pkg::*;

    logic                 s_accept;
    logic [BRIGHT_W-1:0]  brightness_reg;
    logic                 m_tvalid_reg;
    result_t              m_res_reg;
    result_t              seq_res;

    // result register frees itself in the same cycle it is taken
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // brightness register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_RESET;
        end else if (cfg_wr_en) begin
            brightness_reg <= cfg_wr_data;
        end
    end

    ltw_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_accept),
        .op         (s_tuser[0]),
        .with_setup (s_tuser[1]),
        .seg_data   (s_tdata),
        .brightness (brightness_reg),
        .res        (seq_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_res_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_res_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !s_accept)
        else $error("result overwritten while stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted item gave no result");

    a_idle_pins_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3] && !m_tdata[5] && !m_tdata[4]) |->
            (m_tdata[0] && m_tdata[1] && m_tdata[2]))
        else $error("pins not idle high while idle");

endmodule
